// File: sv/eia_pkg.sv
package eia_pkg;

    localparam int VALUE_WIDTH = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_LT  = 3'd5;
    localparam logic [2:0] OP_GT  = 3'd6;
    localparam logic [2:0] OP_NEG = 3'd7;

    localparam logic [1:0] K_FIN = 2'd0;
    localparam logic [1:0] K_POS = 2'd1;
    localparam logic [1:0] K_NEG = 2'd2;

    // Class of work that the back end carries out.
    typedef enum logic [1:0] {
        CL_FIXED = 2'd0,
        CL_ADD   = 2'd1,
        CL_MUL   = 2'd2,
        CL_DIV   = 2'd3
    } cls_t;

    // Flip an infinity; finite stays finite.
    function automatic logic [1:0] flip_kind(input logic [1:0] k);
        flip_kind = (k == K_POS) ? K_NEG : (k == K_NEG) ? K_POS : K_FIN;
    endfunction

endpackage

// File: sv/eia_front.sv
// Front end: normalizes kinds, settles every infinite and compare case, and
// prepares magnitudes and signs for the finite arithmetic in the back end.
module eia_front #(
    parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             opcode,
    input  logic [1:0]             a_kind_in,
    input  logic [VALUE_WIDTH-1:0] a_value,
    input  logic [1:0]             b_kind_in,
    input  logic [VALUE_WIDTH-1:0] b_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output eia_pkg::cls_t          out_cls,
    output logic [1:0]             out_kind,
    output logic                   out_cmp,
    output logic                   out_dz,
    output logic                   out_neg,
    output logic [VALUE_WIDTH-1:0] out_x,
    output logic [VALUE_WIDTH-1:0] out_y
);

    logic [1:0] ka, kb;
    logic       ia, ib, an, bn, sa_lt, sb_gt;
    logic [1:0] ra, rb;
    eia_pkg::cls_t cls;
    logic [1:0] kind;
    logic cmp, dz, neg;
    logic [VALUE_WIDTH-1:0] x, y;

    logic                   valid_reg;
    eia_pkg::cls_t          cls_reg;
    logic [1:0]             kind_reg;
    logic                   cmp_reg, dz_reg, neg_reg;
    logic [VALUE_WIDTH-1:0] x_reg, y_reg;

    // Classification of one word.
    always_comb begin
        ka = (a_kind_in == 2'd3) ? eia_pkg::K_FIN : a_kind_in;
        kb = (b_kind_in == 2'd3) ? eia_pkg::K_FIN : b_kind_in;
        ia = ka != eia_pkg::K_FIN;
        ib = kb != eia_pkg::K_FIN;
        an = a_value[VALUE_WIDTH-1];
        bn = b_value[VALUE_WIDTH-1];
        sa_lt = $signed(a_value) < $signed(b_value);
        sb_gt = $signed(a_value) > $signed(b_value);
        ra = (ka == eia_pkg::K_NEG) ? 2'd0 : (ka == eia_pkg::K_POS) ? 2'd2 : 2'd1;
        rb = (kb == eia_pkg::K_NEG) ? 2'd0 : (kb == eia_pkg::K_POS) ? 2'd2 : 2'd1;
        cls = eia_pkg::CL_FIXED;
        kind = eia_pkg::K_FIN;
        cmp = 1'b0;
        dz = 1'b0;
        neg = 1'b0;
        x = a_value;
        y = b_value;
        unique case (opcode)
            eia_pkg::OP_ADD: begin
                if (ia) kind = ka;
                else if (ib) kind = kb;
                else cls = eia_pkg::CL_ADD;
            end
            eia_pkg::OP_SUB: begin
                if (ia) kind = ka;
                else if (ib) kind = eia_pkg::flip_kind(kb);
                else begin
                    cls = eia_pkg::CL_ADD;
                    y = ~b_value;
                    neg = 1'b1;
                end
            end
            eia_pkg::OP_MUL, eia_pkg::OP_DIV: begin
                if (ia && ib) kind = (ka == kb) ? eia_pkg::K_POS : eia_pkg::K_NEG;
                else if (ia) kind = bn ? eia_pkg::flip_kind(ka) : ka;
                else if (ib) begin
                    if (opcode == eia_pkg::OP_MUL)
                        kind = an ? eia_pkg::flip_kind(kb) : kb;
                end else if (opcode == eia_pkg::OP_MUL) cls = eia_pkg::CL_MUL;
                else if (b_value == '0) dz = 1'b1;
                else begin
                    cls = eia_pkg::CL_DIV;
                    x = an ? (~a_value + 1'b1) : a_value;
                    y = bn ? (~b_value + 1'b1) : b_value;
                    neg = an ^ bn;
                end
            end
            eia_pkg::OP_EQ: cmp = !ia && !ib && (a_value == b_value);
            eia_pkg::OP_LT: cmp = (ia || ib) ? (ra < rb) : sa_lt;
            eia_pkg::OP_GT: cmp = (ia || ib) ? (ra > rb) : sb_gt;
            default: begin
                if (ia) kind = eia_pkg::flip_kind(ka);
                else begin
                    cls = eia_pkg::CL_ADD;
                    x = '0;
                    y = ~a_value;
                    neg = 1'b1;
                end
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register toward the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            cls_reg <= cls;
            kind_reg <= kind;
            cmp_reg <= cmp;
            dz_reg <= dz;
            neg_reg <= neg;
            x_reg <= x;
            y_reg <= y;
        end
    end

    assign out_valid = valid_reg;
    assign out_cls = cls_reg;
    assign out_kind = kind_reg;
    assign out_cmp = cmp_reg;
    assign out_dz = dz_reg;
    assign out_neg = neg_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;

endmodule

// File: sv/eia_queue.sv
// Two-entry queue between front and back end; takes a word each cycle while not full.
module eia_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_reg, rd_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_reg] <= in_data;
    end

endmodule

// File: sv/eia_div.sv
// Restoring divider on magnitudes, one quotient bit per stage, fully
// pipelined so that a new word enters every cycle while en is high.
module eia_div #(
    parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH,
    parameter int TAG_WIDTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [VALUE_WIDTH-1:0] in_num,
    input  logic [VALUE_WIDTH-1:0] in_den,
    input  logic [TAG_WIDTH-1:0]   in_tag,
    output logic                   out_valid,
    output logic [VALUE_WIDTH-1:0] out_quo,
    output logic [TAG_WIDTH-1:0]   out_tag
);

    localparam int N = VALUE_WIDTH;

    // Inputs of each stage: the first takes the ports, the rest the registers.
    logic                 st_v   [N];
    logic [N-1:0]         st_rem [N];
    logic [N-1:0]         st_num [N];
    logic [N-1:0]         st_den [N];
    logic [TAG_WIDTH-1:0] st_tag [N];
    logic [N:0]           trial  [N];
    logic [N:0]           diff   [N];

    logic                 v_reg   [N];
    logic [N-1:0]         rem_reg [N];
    logic [N-1:0]         num_reg [N];
    logic [N-1:0]         den_reg [N];
    logic [TAG_WIDTH-1:0] tag_reg [N];

    // Trial subtraction of every stage; num shifts out the dividend and in the quotient.
    always_comb begin
        st_v[0] = in_valid;
        st_rem[0] = '0;
        st_num[0] = in_num;
        st_den[0] = in_den;
        st_tag[0] = in_tag;
        for (int i = 1; i < N; i++) begin
            st_v[i] = v_reg[i-1];
            st_rem[i] = rem_reg[i-1];
            st_num[i] = num_reg[i-1];
            st_den[i] = den_reg[i-1];
            st_tag[i] = tag_reg[i-1];
        end
        for (int i = 0; i < N; i++) begin
            trial[i] = {st_rem[i], st_num[i][N-1]};
            diff[i] = trial[i] - {1'b0, st_den[i]};
        end
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= st_v[i];
            end
            if (en) begin
                rem_reg[i] <= diff[i][N] ? trial[i][N-1:0] : diff[i][N-1:0];
                num_reg[i] <= {st_num[i][N-2:0], !diff[i][N]};
                den_reg[i] <= st_den[i];
                tag_reg[i] <= st_tag[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo = num_reg[N-1];
    assign out_tag = tag_reg[N-1];

endmodule

// File: sv/eia_back.sv
// Back end: a pipeline as deep as the divider. Adds and multiplies run in the
// first stage and ride along; the whole pipe stalls when the output holds.
module eia_back #(
    parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  eia_pkg::cls_t          in_cls,
    input  logic [1:0]             in_kind,
    input  logic                   in_cmp,
    input  logic                   in_dz,
    input  logic                   in_neg,
    input  logic [VALUE_WIDTH-1:0] in_x,
    input  logic [VALUE_WIDTH-1:0] in_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_cmp,
    output logic                   out_dz
);

    // tag: value, is_div, neg, dz, cmp, kind
    localparam int TW = VALUE_WIDTH + 6;

    logic [VALUE_WIDTH-1:0] early;
    logic [TW-1:0]          tag_in, tag_out;
    logic                   en, dv;
    logic [VALUE_WIDTH-1:0] quo, qs;

    // Finite add (subtract as a plus not b plus one) and wrapping multiply.
    always_comb begin
        case (in_cls)
            eia_pkg::CL_ADD: early = in_x + in_y + {{(VALUE_WIDTH-1){1'b0}}, in_neg};
            eia_pkg::CL_MUL: early = in_x * in_y;
            default:         early = '0;
        endcase
    end

    assign tag_in = {early, in_cls == eia_pkg::CL_DIV, in_neg, in_dz, in_cmp, in_kind};
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    eia_div #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .TAG_WIDTH(TW)
    ) u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(en),
        .in_valid(in_valid),
        .in_num(in_x),
        .in_den(in_y),
        .in_tag(tag_in),
        .out_valid(dv),
        .out_quo(quo),
        .out_tag(tag_out)
    );

    assign qs = tag_out[4] ? (~quo + 1'b1) : quo;

    assign out_valid = dv;
    assign out_kind = tag_out[1:0];
    assign out_cmp = tag_out[2];
    assign out_dz = tag_out[3];
    assign out_value = tag_out[5] ? qs : tag_out[TW-1:6];

endmodule

// File: sv/extended_integer_alu_with_infinity_top.sv
// ALU over signed integers extended with plus and minus infinity. One word is
// accepted per cycle when the output is taken; a result word passes through
// the front register, the two-entry queue and the pipelined divider (one
// quotient bit per stage), and the whole back end stalls while the output is
// held. Infinite and compare cases are settled in the front end; the back end
// does finite add, multiply, divide.
module extended_integer_alu_with_infinity_top #(
    parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], a_kind[4:3], a_value, b_kind, b_value, zero fill
    input  logic [((2*VALUE_WIDTH+7+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_kind[1:0], res_value, compare_true, divide_by_zero, zero fill
    output logic [((VALUE_WIDTH+4+7)/8)*8-1:0]   m_tdata
);

    localparam int QW = VALUE_WIDTH*2 + 7;
    localparam int MW = ((VALUE_WIDTH+4+7)/8)*8;

    logic f_valid, f_ready, q_valid, q_ready;
    eia_pkg::cls_t f_cls, q_cls;
    logic [1:0] f_kind, q_kind, r_kind;
    logic f_cmp, f_dz, f_neg, q_cmp, q_dz, q_neg, r_cmp, r_dz;
    logic [VALUE_WIDTH-1:0] f_x, f_y, q_x, q_y, r_val;
    logic [QW-1:0] q_data;

    eia_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tdata[2:0]),
        .a_kind_in(s_tdata[4:3]),
        .a_value(s_tdata[5+VALUE_WIDTH-1:5]),
        .b_kind_in(s_tdata[6+VALUE_WIDTH:5+VALUE_WIDTH]),
        .b_value(s_tdata[7+2*VALUE_WIDTH-1:7+VALUE_WIDTH]),
        .out_valid(f_valid), .out_ready(f_ready),
        .out_cls(f_cls), .out_kind(f_kind), .out_cmp(f_cmp),
        .out_dz(f_dz), .out_neg(f_neg), .out_x(f_x), .out_y(f_y)
    );

    eia_queue #(.WIDTH(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready),
        .in_data({f_y, f_x, f_neg, f_dz, f_cmp, f_kind, f_cls}),
        .out_valid(q_valid), .out_ready(q_ready),
        .out_data(q_data)
    );

    assign q_cls = eia_pkg::cls_t'(q_data[1:0]);
    assign q_kind = q_data[3:2];
    assign q_cmp = q_data[4];
    assign q_dz = q_data[5];
    assign q_neg = q_data[6];
    assign q_x = q_data[7+VALUE_WIDTH-1:7];
    assign q_y = q_data[QW-1:7+VALUE_WIDTH];

    eia_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready),
        .in_cls(q_cls), .in_kind(q_kind), .in_cmp(q_cmp), .in_dz(q_dz),
        .in_neg(q_neg), .in_x(q_x), .in_y(q_y),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(r_kind), .out_value(r_val), .out_cmp(r_cmp), .out_dz(r_dz)
    );

    assign m_tdata = MW'({r_dz, r_cmp, r_val, r_kind});

endmodule
